// ----- src/spl_pkg.sv -----
// Shared types and codes for the sorted priority list.
package spl_pkg;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_APPEND = 3'd1,
    OP_REMOVE = 3'd2,
    OP_READ   = 3'd3,
    OP_SORT   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BLANK  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SEL_HOLD  = 2'd0,
    SEL_NEW   = 2'd1,
    SEL_LEFT  = 2'd2,
    SEL_RIGHT = 2'd3
  } sel_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_SORT = 2'd2
  } state_t;

  typedef struct packed {
    logic ge_new;
    logic lt_right;
  } cell_flags_t;

endpackage

// ----- src/spl_cell.sv -----
// One slot of the list: holds an entry, compares it and loads from the command or its neighbours.
module spl_cell #(
  parameter int KEY_WIDTH = 8,
  parameter int ID_WIDTH  = 8
) (
  input  logic                 clk,
  input  spl_pkg::sel_t        sel,
  input  logic [ID_WIDTH-1:0]  new_id,
  input  logic [KEY_WIDTH-1:0] new_key,
  input  logic [ID_WIDTH-1:0]  left_id,
  input  logic [KEY_WIDTH-1:0] left_key,
  input  logic [ID_WIDTH-1:0]  right_id,
  input  logic [KEY_WIDTH-1:0] right_key,
  output logic [ID_WIDTH-1:0]  id,
  output logic [KEY_WIDTH-1:0] key,
  output spl_pkg::cell_flags_t flags
);
  import spl_pkg::*;

  always_ff @(posedge clk) begin
    case (sel)
      SEL_NEW: begin
        id  <= new_id;
        key <= new_key;
      end
      SEL_LEFT: begin
        id  <= left_id;
        key <= left_key;
      end
      SEL_RIGHT: begin
        id  <= right_id;
        key <= right_key;
      end
      default: begin
        id  <= id;
        key <= key;
      end
    endcase
  end

  assign flags.ge_new   = (key >= new_key);
  assign flags.lt_right = (key < right_key);

endmodule

// ----- src/sorted_priority_list.sv -----
// Top level of the sorted priority list: control and the row of slot cells.
//
// A command word is taken when start is high and busy is low. Insert sorted, append,
// remove and read each register the command first, then run an execute step in which
// every cell of the chain compares and shifts at once and the result is registered.
// Sort runs one odd-even exchange pass per cycle over the chain, CAPACITY passes in
// all, when more than one entry is stored; otherwise it finishes in the execute step.
// The result is shown for exactly one cycle with done high and cannot be held off; a
// new command may be accepted in that same cycle.
module sorted_priority_list #(
  parameter int CAPACITY  = 32,
  parameter int KEY_WIDTH = 8,
  parameter int ID_WIDTH  = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [2:0]                           op,
  input  logic [ID_WIDTH-1:0]                  entry_id,
  input  logic [KEY_WIDTH-1:0]                 entry_key,
  input  logic [$clog2(CAPACITY+1)-1:0]        position,
  input  logic                                 is_blank,
  output logic                                 done,
  output logic [1:0]                           status,
  output logic [ID_WIDTH-1:0]                  out_id,
  output logic [KEY_WIDTH-1:0]                 out_key,
  output logic [$clog2(CAPACITY+1)-1:0]        fill
);
  import spl_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  state_t                state, state_next;
  logic [CW-1:0]         count, count_next;
  logic [IW-1:0]         pass, pass_next;

  logic [2:0]            cmd_op;
  logic [ID_WIDTH-1:0]   cmd_id;
  logic [KEY_WIDTH-1:0]  cmd_key;
  logic [CW-1:0]         cmd_pos;
  logic                  cmd_blank;

  logic                  done_next;
  logic [1:0]            status_next;
  logic [ID_WIDTH-1:0]   out_id_next;
  logic [KEY_WIDTH-1:0]  out_key_next;

  logic [ID_WIDTH-1:0]   cell_id  [CAPACITY];
  logic [KEY_WIDTH-1:0]  cell_key [CAPACITY];
  cell_flags_t           flags    [CAPACITY];
  sel_t                  sel      [CAPACITY];

  logic [CAPACITY-1:0]   stop;
  logic [CAPACITY-1:0]   past;
  logic [CAPACITY-1:0]   swp;

  logic [CW-1:0]         pos_m1;
  logic                  pos_ok;

  assign busy   = (state != S_IDLE);
  assign pos_m1 = cmd_pos - CW'(1);
  assign pos_ok = (cmd_pos != '0) && (cmd_pos <= count);

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [ID_WIDTH-1:0]  l_id, r_id;
      logic [KEY_WIDTH-1:0] l_key, r_key;

      if (g == 0) begin : g_first
        assign l_id  = cell_id[g];
        assign l_key = cell_key[g];
      end else begin : g_inner_l
        assign l_id  = cell_id[g-1];
        assign l_key = cell_key[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
        assign r_id  = cell_id[g];
        assign r_key = cell_key[g];
      end else begin : g_inner_r
        assign r_id  = cell_id[g+1];
        assign r_key = cell_key[g+1];
      end

      spl_cell #(
        .KEY_WIDTH (KEY_WIDTH),
        .ID_WIDTH  (ID_WIDTH)
      ) u_cell (
        .clk       (clk),
        .sel       (sel[g]),
        .new_id    (cmd_id),
        .new_key   (cmd_key),
        .left_id   (l_id),
        .left_key  (l_key),
        .right_id  (r_id),
        .right_key (r_key),
        .id        (cell_id[g]),
        .key       (cell_key[g]),
        .flags     (flags[g])
      );

      assign stop[g] = (CW'(g) >= count) ||
                       ((cmd_op == OP_INSERT) && !flags[g].ge_new);

      if (g < CAPACITY - 1) begin : g_past
        assign past[g+1] = past[g] | stop[g];
      end

      if (g == CAPACITY - 1) begin : g_swp_last
        assign swp[g] = 1'b0;
      end else begin : g_swp
        assign swp[g] = (CW'(g + 1) < count) && flags[g].lt_right &&
                        (1'(g) == pass[0]);
      end
    end
  endgenerate

  assign past[0] = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    pass    <= pass_next;
    status  <= status_next;
    out_id  <= out_id_next;
    out_key <= out_key_next;
    fill    <= count_next;
    if (start && !busy) begin
      cmd_op    <= op;
      cmd_id    <= entry_id;
      cmd_key   <= entry_key;
      cmd_pos   <= position;
      cmd_blank <= is_blank;
    end
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    pass_next    = pass;
    done_next    = 1'b0;
    status_next  = status;
    out_id_next  = out_id;
    out_key_next = out_key;
    for (int i = 0; i < CAPACITY; i++) begin
      sel[i] = SEL_HOLD;
    end

    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        state_next   = S_IDLE;
        done_next    = 1'b1;
        status_next  = ST_OK;
        out_id_next  = '0;
        out_key_next = '0;
        case (cmd_op)
          OP_INSERT, OP_APPEND: begin
            if (cmd_blank) begin
              status_next = ST_BLANK;
            end else if (count == CW'(CAPACITY)) begin
              status_next = ST_FULL;
            end else begin
              for (int i = 0; i < CAPACITY; i++) begin
                if (past[i]) begin
                  sel[i] = SEL_LEFT;
                end else if (stop[i]) begin
                  sel[i] = SEL_NEW;
                end
              end
              count_next = count + CW'(1);
            end
          end
          OP_REMOVE, OP_READ: begin
            if (!pos_ok) begin
              status_next = ST_BADPOS;
            end else begin
              out_id_next  = cell_id[pos_m1[IW-1:0]];
              out_key_next = cell_key[pos_m1[IW-1:0]];
              if (cmd_op == OP_REMOVE) begin
                for (int i = 0; i < CAPACITY; i++) begin
                  if (CW'(i) >= pos_m1) begin
                    sel[i] = SEL_RIGHT;
                  end
                end
                count_next = count - CW'(1);
              end
            end
          end
          OP_SORT: begin
            if (count > CW'(1)) begin
              state_next = S_SORT;
              done_next  = 1'b0;
              pass_next  = '0;
            end
          end
          default: begin
          end
        endcase
      end

      S_SORT: begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (swp[i]) begin
            sel[i] = SEL_RIGHT;
          end else if (i > 0 && swp[(i > 0) ? i - 1 : 0]) begin
            sel[i] = SEL_LEFT;
          end
        end
        pass_next = pass + IW'(1);
        if (pass == IW'(CAPACITY - 1)) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
